// ----- hdl/point_in_polygon_classifier_core_assert.svh -----
// ---------------------------------------------------------------------------
// Point-in-polygon classifier assertion macros
// Shared macros for the concurrent checks of the classifier core.
// ---------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_CLASSIFIER_CORE_ASSERT_SVH
`define POINT_IN_POLYGON_CLASSIFIER_CORE_ASSERT_SVH

// Check that a condition implies another condition in the same cycle.
`define PPC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another condition in the next cycle.
`define PPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ppc_pkg.sv -----
// ---------------------------------------------------------------------------
// Point-in-polygon classifier package
// Sizes, command codes, status codes and shared types of the classifier.
// ---------------------------------------------------------------------------
package ppc_pkg;

    // Vertex table and coordinate sizing
    localparam int MAX_VERTICES = 64;
    localparam int COORD_WIDTH  = 32;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int DIFF_W       = COORD_WIDTH + 1;
    localparam int PROD_W       = 2 * DIFF_W;

    // Command queue between front and back (power of two depth)
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Input opcodes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_TEST   = 2'd2;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    // Command kinds after classification
    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_CLEAR,
        CMD_APPEND,
        CMD_TEST
    } cmd_kind_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // Queued command
    typedef struct packed {
        cmd_kind_t kind;
        coord_t    x;
        coord_t    y;
    } cmd_t;

    // Crossing report of the edge pipeline
    typedef struct packed {
        logic valid;
        logic flip;
    } edge_hit_t;

    // Sign-extend or wrap a 32-bit input coordinate to the coordinate width
    function automatic coord_t load_coord(input logic signed [31:0] raw);
        return COORD_WIDTH'(raw);
    endfunction

    // Map an opcode to its command kind
    function automatic cmd_kind_t classify(input logic [1:0] op);
        cmd_kind_t kind;
        unique case (op)
            OP_CLEAR:  kind = CMD_CLEAR;
            OP_APPEND: kind = CMD_APPEND;
            OP_TEST:   kind = CMD_TEST;
            default:   kind = CMD_NOP;
        endcase
        return kind;
    endfunction

endpackage

// ----- hdl/ppc_front.sv -----
// ---------------------------------------------------------------------------
// Classifier front end
// Accepts input transactions, classifies the opcode and queues the command.
// ---------------------------------------------------------------------------
module ppc_front
    import ppc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output cmd_t               cmd
);

    cmd_t              queue_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg;
    logic [QCNT_W-1:0] fill_next;
    logic              push;
    logic              pop;
    cmd_t              new_cmd;

    // Accept while the queue has room
    assign in_ready  = (fill_reg != QCNT_W'(QUEUE_DEPTH));
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = queue_mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    // Classify the incoming transaction
    always_comb
    begin
        new_cmd.kind = classify(opcode);
        new_cmd.x    = load_coord(coord_x);
        new_cmd.y    = load_coord(coord_y);
    end

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the queued command
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

// ----- hdl/ppc_edge_unit.sv -----
// ---------------------------------------------------------------------------
// Classifier edge pipeline
// Forms one polygon edge per cycle from consecutive vertex reads and reports
// whether the edge crosses the ray left of the test point.
// ---------------------------------------------------------------------------
module ppc_edge_unit
    import ppc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      vtx_valid,
    input  logic      vtx_edge,
    input  coord_t    vtx_x,
    input  coord_t    vtx_y,
    input  coord_t    pt_x,
    input  coord_t    pt_y,
    output edge_hit_t hit,
    output logic      busy
);

    coord_t                    prev_x_reg;
    coord_t                    prev_y_reg;

    logic                      sa_valid_reg;
    logic                      sa_qual_reg;
    logic signed [DIFF_W-1:0]  a_reg;
    logic signed [DIFF_W-1:0]  b_reg;
    logic signed [DIFF_W-1:0]  c_reg;
    logic signed [DIFF_W-1:0]  d_reg;

    logic                      sb_valid_reg;
    logic                      sb_qual_reg;
    logic                      sb_dpos_reg;
    logic signed [PROD_W-1:0]  lh_reg;
    logic signed [PROD_W-1:0]  rh_reg;

    logic                      straddle;
    logic                      left_of;
    logic                      qual_next;
    logic signed [PROD_W-1:0]  lh_next;
    logic signed [PROD_W-1:0]  rh_next;
    logic                      below;

    // Edge test: current vertex is i, previous vertex is j
    always_comb
    begin
        straddle  = ((vtx_y < pt_y) && (prev_y_reg >= pt_y))
                 || ((prev_y_reg < pt_y) && (vtx_y >= pt_y));
        left_of   = (vtx_x <= pt_x) || (prev_x_reg <= pt_x);
        qual_next = vtx_edge && straddle && left_of;
    end

    // Cross-multiply terms
    always_comb
    begin
        lh_next = a_reg * b_reg;
        rh_next = c_reg * d_reg;
    end

    // Compare the products with the sign of the edge's y span
    always_comb
    begin
        below = sb_dpos_reg ? (lh_reg < rh_reg) : (rh_reg < lh_reg);
    end

    assign hit.valid = sb_valid_reg;
    assign hit.flip  = sb_qual_reg && below;
    assign busy      = sa_valid_reg || sb_valid_reg;

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_valid_reg <= 1'b0;
            sb_valid_reg <= 1'b0;
        end
        else
        begin
            sa_valid_reg <= vtx_valid;
            sb_valid_reg <= sa_valid_reg;
        end
    end

    // Stage payloads and previous vertex
    always_ff @(posedge clk)
    begin
        if (vtx_valid)
        begin
            prev_x_reg  <= vtx_x;
            prev_y_reg  <= vtx_y;
            sa_qual_reg <= qual_next;
            a_reg       <= DIFF_W'(pt_y) - DIFF_W'(vtx_y);
            b_reg       <= DIFF_W'(prev_x_reg) - DIFF_W'(vtx_x);
            c_reg       <= DIFF_W'(pt_x) - DIFF_W'(vtx_x);
            d_reg       <= DIFF_W'(prev_y_reg) - DIFF_W'(vtx_y);
        end
        if (sa_valid_reg)
        begin
            sb_qual_reg <= sa_qual_reg;
            sb_dpos_reg <= (d_reg > 0);
            lh_reg      <= lh_next;
            rh_reg      <= rh_next;
        end
    end

endmodule

// ----- hdl/ppc_back.sv -----
// ---------------------------------------------------------------------------
// Classifier back end
// Executes queued commands: keeps the vertex table, walks the polygon edges
// for a test and holds each result in the output register.
// ---------------------------------------------------------------------------
`include "point_in_polygon_classifier_core_assert.svh"

module ppc_back
    import ppc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  cmd_t       cmd,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       inside_res,
    output logic [1:0] status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] walk_idx_reg;
    logic [CNT_W-1:0] walk_idx_next;
    coord_t           px_reg;
    coord_t           px_next;
    coord_t           py_reg;
    coord_t           py_next;
    logic             inside_reg;
    logic             inside_next;
    status_t          res_status_reg;
    status_t          res_status_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_inside_reg;
    logic             out_inside_next;
    status_t          out_status_reg;
    status_t          out_status_next;

    // Vertex table
    coord_t           vertex_x_store [MAX_VERTICES];
    coord_t           vertex_y_store [MAX_VERTICES];
    coord_t           rd_x_reg;
    coord_t           rd_y_reg;
    logic             rd_valid_reg;
    logic             rd_edge_reg;

    logic             pop;
    logic             wr_en;
    logic             rd_en;
    logic             rd_edge;
    logic [IDX_W-1:0] rd_addr;
    logic [CNT_W-1:0] last_idx;
    edge_hit_t        hit;
    logic             edge_busy;

    assign cmd_ready  = (state_reg == ST_IDLE);
    assign pop        = cmd_valid && cmd_ready;
    assign last_idx   = count_reg - CNT_W'(1);
    assign out_valid  = out_valid_reg;
    assign inside_res = out_inside_reg;
    assign status     = out_status_reg;

    // Command sequencing
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        walk_idx_next   = walk_idx_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        inside_next     = inside_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_inside_next = out_inside_reg;
        out_status_next = out_status_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        rd_edge         = 1'b0;
        rd_addr         = walk_idx_reg[IDX_W-1:0];

        // Drop the held result once it is taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Toggle on each crossing edge
        if (hit.valid && hit.flip)
        begin
            inside_next = ~inside_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    inside_next     = 1'b0;
                    res_status_next = STATUS_OK;
                    state_next      = ST_DONE;
                    unique case (cmd.kind)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_APPEND:
                        begin
                            if (count_reg < CNT_W'(MAX_VERTICES))
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                res_status_next = STATUS_FULL;
                            end
                        end
                        CMD_TEST:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                // Prime the walk with the closing vertex
                                px_next       = cmd.x;
                                py_next       = cmd.y;
                                rd_en         = 1'b1;
                                rd_addr       = last_idx[IDX_W-1:0];
                                walk_idx_next = '0;
                                state_next    = ST_WALK;
                            end
                        end
                        default:
                        begin
                            res_status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                rd_en         = 1'b1;
                rd_edge       = 1'b1;
                walk_idx_next = walk_idx_reg + CNT_W'(1);
                if (walk_idx_reg == last_idx)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_valid_reg && !edge_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_inside_next = inside_reg;
                    out_status_next = res_status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            rd_valid_reg   <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_idx_reg   <= walk_idx_next;
        px_reg         <= px_next;
        py_reg         <= py_next;
        inside_reg     <= inside_next;
        res_status_reg <= res_status_next;
        out_inside_reg <= out_inside_next;
        out_status_reg <= out_status_next;
        rd_edge_reg    <= rd_edge;
    end

    // Write and read the vertex table
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            vertex_x_store[count_reg[IDX_W-1:0]] <= cmd.x;
            vertex_y_store[count_reg[IDX_W-1:0]] <= cmd.y;
        end
        if (rd_en)
        begin
            rd_x_reg <= vertex_x_store[rd_addr];
            rd_y_reg <= vertex_y_store[rd_addr];
        end
    end

    ppc_edge_unit u_edge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .vtx_valid (rd_valid_reg),
        .vtx_edge  (rd_edge_reg),
        .vtx_x     (rd_x_reg),
        .vtx_y     (rd_y_reg),
        .pt_x      (px_reg),
        .pt_y      (py_reg),
        .hit       (hit),
        .busy      (edge_busy)
    );

    // Checks
    `PPC_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_VERTICES), "vertex count overflow")
    `PPC_ASSERT_SAME(a_pipe_in_test, edge_busy || rd_valid_reg, state_reg == ST_WALK || state_reg == ST_DRAIN, "edge pipeline busy outside a test")
    `PPC_ASSERT_NEXT(a_full_drop, pop && cmd.kind == CMD_APPEND && count_reg == CNT_W'(MAX_VERTICES), res_status_reg == STATUS_FULL && $stable(count_reg), "full table append not dropped")
    `PPC_ASSERT_NEXT(a_result_load, state_reg == ST_DONE && (!out_valid_reg || out_ready), out_valid_reg && state_reg == ST_IDLE, "result not loaded")

endmodule

// ----- hdl/point_in_polygon_classifier_core.sv -----
// ---------------------------------------------------------------------------
// Point-in-polygon classifier core
// Even-odd ray casting over a stored vertex table, one result per transaction.
// ---------------------------------------------------------------------------
// Every input transaction (clear, append, test, or an ignored opcode) returns
// exactly one result. A front end queues up to two commands so that input
// keeps flowing while the back end works and a result waits in the output
// register. A test over N stored vertices reads the vertex table once per
// cycle through its single read port, N + 1 reads including the closing
// vertex, then drains the edge pipeline (registered difference and
// cross-multiply stages, then a combinational compare). A test of an empty
// table answers outside with the empty status, and an append to a full
// table is dropped with the full status.
module point_in_polygon_classifier_core
    import ppc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               inside_res,
    output logic [1:0]         status
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    ppc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    ppc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .inside_res (inside_res),
        .status     (status)
    );

endmodule
